FILE: rtl/biquad_eq_chain_soft_clip_core_macros.svh
`ifndef BIQUAD_EQ_CHAIN_SOFT_CLIP_CORE_MACROS_SVH
`define BIQUAD_EQ_CHAIN_SOFT_CLIP_CORE_MACROS_SVH

// Check that a property holds at every rising edge outside reset.
`define BQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that an expression is never true outside reset.
`define BQ_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

FILE: rtl/bqeq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bqeq_pkg;

   localparam int BANDS       = 8;
   localparam int CHANNELS    = 2;
   localparam int TANH_BITS   = 8;
   localparam int TANH_POINTS = 1 << TANH_BITS;
   localparam int STAGES      = BANDS + 2;
   localparam int SLOTS       = 7;
   localparam int COEF_DEPTH  = STAGES * SLOTS;
   localparam int DELAY_DEPTH = STAGES * CHANNELS;
   localparam int COEF_AW     = $clog2(COEF_DEPTH);
   localparam int DELAY_AW    = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
   localparam int STAGE_CW    = $clog2(STAGES);

   localparam logic [1:0] MODE_AUDIO = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [2:0] SLOT_B0     = 3'd0;
   localparam logic [2:0] SLOT_B1     = 3'd1;
   localparam logic [2:0] SLOT_B2     = 3'd2;
   localparam logic [2:0] SLOT_A1     = 3'd3;
   localparam logic [2:0] SLOT_A2     = 3'd4;
   localparam logic [2:0] SLOT_DRIVE  = 3'd5;
   localparam logic [2:0] SLOT_RDRIVE = 3'd6;

   localparam logic [1:0] CSR_GAIN = 2'd0;
   localparam logic [1:0] CSR_HP   = 2'd1;
   localparam logic [1:0] CSR_LP   = 2'd2;

   localparam logic [23:0] GAIN_RESET = 24'd1048576;
   localparam logic [31:0] Q27_ONE    = 32'h0800_0000;

   typedef logic [31:0] tanh_rom_type [0:TANH_POINTS];

   function automatic logic [63:0] mul_q56(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] ah, al, bh, bl;
      ah = a >> 32;
      al = a & 64'hFFFF_FFFF;
      bh = b >> 32;
      bl = b & 64'hFFFF_FFFF;
      return ((ah * bh) << 8) + ((ah * bl + al * bh) >> 24) + ((al * bl) >> 56);
   endfunction

   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [64:0] rem;
      q   = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem  = rem - {1'b0, den};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic tanh_rom_type build_tanh_rom();
      tanh_rom_type rom;
      logic [63:0] term, r, e, num, den, one;
      one  = 64'd1 << 56;
      term = one;
      r    = one;
      e    = one;
      for (int n = 1; n < 40; n++) begin
         if (term != 64'd0) begin
            term = udiv64(term * 64'd16, 64'(TANH_POINTS) * 64'(n));
            if ((n & 1) != 0) r = r - term;
            else r = r + term;
         end
      end
      for (int k = 0; k <= TANH_POINTS; k++) begin
         num    = (one - e) >> 26;
         den    = (one + e) >> 26;
         rom[k] = 32'(udiv64((num << 30) + (den >> 1), den));
         e      = mul_q56(e, r);
      end
      return rom;
   endfunction

   localparam tanh_rom_type TANH_ROM = build_tanh_rom();

endpackage

`default_nettype wire

FILE: rtl/biquad_eq_chain_soft_clip_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Stereo equalizer: high-pass, peaking bands with optional tanh soft clip, low-pass, makeup
// gain, saturated to 24 bits. One item is worked on at a time through a single shared 33x33
// multiplier and a coefficient memory with separate read and write addresses. An audio item
// runs the biquad steps for each active stage, the clip steps for each band whose drive is
// nonzero, and then the gain steps. The delay and coefficient memories need no clearing pass
// after reset. req_stall is high while an audio item is in work, including while its finished
// sample waits for the output register to be free.
`include "biquad_eq_chain_soft_clip_core_macros.svh"

module biquad_eq_chain_soft_clip_core
   import bqeq_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_mode,
   input  wire logic               req_channel,
   input  wire logic signed [23:0] req_sample_in,
   input  wire logic [3:0]         req_stage_index,
   input  wire logic [2:0]         req_slot_index,
   input  wire logic signed [31:0] req_coef_word,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [23:0]      rsp_sample_out,
   output logic                    rsp_channel_out,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [23:0]        csr_data
);

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_B0   = 5'd1;
   localparam logic [4:0] ST_B1   = 5'd2;
   localparam logic [4:0] ST_B2   = 5'd3;
   localparam logic [4:0] ST_B3   = 5'd4;
   localparam logic [4:0] ST_B4   = 5'd5;
   localparam logic [4:0] ST_B5   = 5'd6;
   localparam logic [4:0] ST_B6   = 5'd7;
   localparam logic [4:0] ST_C1   = 5'd8;
   localparam logic [4:0] ST_C2   = 5'd9;
   localparam logic [4:0] ST_C3   = 5'd10;
   localparam logic [4:0] ST_C4   = 5'd11;
   localparam logic [4:0] ST_C5   = 5'd12;
   localparam logic [4:0] ST_C6   = 5'd13;
   localparam logic [4:0] ST_M0   = 5'd14;
   localparam logic [4:0] ST_M1   = 5'd15;

   localparam int PW = 66;
   localparam int AW = 44;

   function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v, input int n);
      logic signed [PW-1:0] half;
      half = PW'(1) <<< (n - 1);
      return (v + half) >>> n;
   endfunction

   function automatic logic signed [PW-1:0] sat(input logic signed [PW-1:0] v, input int bits);
      logic signed [PW-1:0] hi, lo;
      hi = (PW'(1) <<< (bits - 1)) - PW'(1);
      lo = -hi - PW'(1);
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

   logic [4:0]                state_ff, state_in;
   logic [STAGE_CW-1:0]       stage_ff, stage_in;
   logic                      ch_ff;
   logic [23:0]               gain_ff;
   logic                      hp_en_ff, lp_en_ff;
   logic                      rsp_valid_ff;
   logic signed [23:0]        rsp_sample_ff;
   logic                      rsp_channel_ff;

   logic signed [31:0]        x_ff, y_ff, t_ff;
   logic signed [AW-1:0]      acc_ff;
   logic signed [PW-1:0]      prod_ff;
   logic [37:0]               mag_ff;
   logic                      neg_ff, big_ff;
   logic [31:0]               t0_ff, t1_ff;
   logic [29:0]               frac_ff;

   logic [31:0]               coef_mem [0:COEF_DEPTH-1];
   logic [COEF_DEPTH-1:0]     coef_vld_ff;
   logic [31:0]               coef_q_ff;
   logic                      coef_qv_ff, coef_q0_ff;
   logic signed [31:0]        coef_eff;
   logic [2:0]                slot_sel;
   logic [COEF_AW-1:0]        coef_rd_addr, coef_wr_addr;
   logic                      coef_we;

   logic [39:0]               d1_mem [0:DELAY_DEPTH-1];
   logic [39:0]               d2_mem [0:DELAY_DEPTH-1];
   logic [DELAY_DEPTH-1:0]    d1_vld_ff, d2_vld_ff;
   logic [39:0]               d1_q_ff, d2_q_ff;
   logic                      d1_qv_ff, d2_qv_ff;
   logic signed [39:0]        d1_eff, d2_eff;
   logic [DELAY_AW-1:0]       d_addr;
   logic                      d1_we, d2_we;
   logic signed [39:0]        d1_wdata, d2_wdata;

   logic signed [32:0]        mul_a, mul_b;
   logic signed [PW-1:0]      rp27, rp30;
   logic                      req_acc, audio_go, out_free, is_band;
   logic [TANH_BITS-1:0]      idx_lo;
   logic signed [PW-1:0]      u_val;
   logic signed [31:0]        t_calc;

   assign req_acc   = req_valid && !req_stall;
   assign audio_go  = req_acc && req_mode == MODE_AUDIO && int'(req_channel) < CHANNELS;
   assign out_free  = !(rsp_valid_ff && rsp_stall);
   assign req_stall = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_out  = rsp_sample_ff;
   assign rsp_channel_out = rsp_channel_ff;

   assign coef_eff = coef_qv_ff ? signed'(coef_q_ff) : (coef_q0_ff ? signed'(Q27_ONE) : 32'sd0);
   assign d1_eff   = d1_qv_ff ? signed'(d1_q_ff) : 40'sd0;
   assign d2_eff   = d2_qv_ff ? signed'(d2_q_ff) : 40'sd0;
   assign rp27     = rnd(prod_ff, 27);
   assign rp30     = rnd(prod_ff, 30);
   assign is_band  = stage_ff != '0 && int'(stage_ff) != STAGES - 1;
   assign u_val    = rnd(prod_ff, 27);
   assign idx_lo   = mag_ff[29 -: TANH_BITS];

   always_comb begin
      case (state_ff)
         ST_B0:   slot_sel = SLOT_B0;
         ST_B1:   slot_sel = SLOT_B1;
         ST_B2:   slot_sel = SLOT_A1;
         ST_B3:   slot_sel = SLOT_B2;
         ST_B4:   slot_sel = SLOT_A2;
         ST_B5:   slot_sel = SLOT_DRIVE;
         default: slot_sel = SLOT_RDRIVE;
      endcase
   end

   assign coef_rd_addr = COEF_AW'(int'(stage_ff) * SLOTS + int'(slot_sel));
   assign coef_wr_addr = COEF_AW'(int'(req_stage_index) * SLOTS + int'(req_slot_index));
   assign coef_we      = req_acc && req_mode == MODE_WRITE
                         && int'(req_stage_index) < STAGES && int'(req_slot_index) < SLOTS;
   assign d_addr       = DELAY_AW'(int'(stage_ff) * CHANNELS + int'(ch_ff));
   assign d1_we        = state_ff == ST_B5;
   assign d2_we        = state_ff == ST_B6;
   assign d1_wdata     = 40'(sat(PW'(acc_ff), 40));
   assign d2_wdata     = 40'(sat(PW'(acc_ff) - rp27, 40));

   always_comb begin
      t_calc = big_ff ? signed'(TANH_ROM[TANH_POINTS])
                      : 32'(signed'(PW'(t0_ff)) + rp30);
      if (neg_ff) t_calc = -t_calc;
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_B1, ST_B2, ST_B4: begin
            mul_a = 33'(coef_eff);
            mul_b = 33'(x_ff);
         end
         ST_B3, ST_B5, ST_B6: begin
            mul_a = 33'(coef_eff);
            mul_b = 33'(y_ff);
         end
         ST_C3: begin
            mul_a = signed'({1'b0, t1_ff}) - signed'({1'b0, t0_ff});
            mul_b = signed'({3'b000, frac_ff});
         end
         ST_C5: begin
            mul_a = 33'(t_ff);
            mul_b = 33'(coef_eff);
         end
         ST_M0, ST_M1: begin
            mul_a = 33'(x_ff);
            mul_b = signed'({9'd0, gain_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      stage_in = stage_ff;
      case (state_ff)
         ST_IDLE: begin
            if (audio_go) begin
               state_in = ST_B0;
               stage_in = hp_en_ff ? STAGE_CW'(0) : STAGE_CW'(1);
            end
         end
         ST_B0: state_in = ST_B1;
         ST_B1: state_in = ST_B2;
         ST_B2: state_in = ST_B3;
         ST_B3: state_in = ST_B4;
         ST_B4: state_in = ST_B5;
         ST_B5: state_in = ST_B6;
         ST_B6, ST_C6: begin
            if (state_ff == ST_B6 && is_band && coef_eff != 32'sd0) begin
               state_in = ST_C1;
            end else if (int'(stage_ff) == STAGES - 1
                         || (int'(stage_ff) == BANDS && !lp_en_ff)) begin
               state_in = ST_M0;
            end else begin
               state_in = ST_B0;
               stage_in = stage_ff + STAGE_CW'(1);
            end
         end
         ST_C1: state_in = ST_C2;
         ST_C2: state_in = ST_C3;
         ST_C3: state_in = ST_C4;
         ST_C4: state_in = ST_C5;
         ST_C5: state_in = ST_C6;
         ST_M0: state_in = ST_M1;
         ST_M1: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         stage_ff       <= '0;
         gain_ff        <= GAIN_RESET;
         hp_en_ff       <= 1'b0;
         lp_en_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         coef_vld_ff    <= '0;
         d1_vld_ff      <= '0;
         d2_vld_ff      <= '0;
      end else begin
         state_ff <= state_in;
         stage_ff <= stage_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GAIN: gain_ff  <= csr_data;
               CSR_HP:   hp_en_ff <= csr_data[0];
               CSR_LP:   lp_en_ff <= csr_data[0];
               default:  ;
            endcase
         end
         if (coef_we) coef_vld_ff[coef_wr_addr] <= 1'b1;
         if (req_acc && req_mode == MODE_CLEAR) begin
            d1_vld_ff <= '0;
            d2_vld_ff <= '0;
         end
         if (d1_we) d1_vld_ff[d_addr] <= 1'b1;
         if (d2_we) d2_vld_ff[d_addr] <= 1'b1;
         if (state_ff == ST_M1 && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (coef_we) coef_mem[coef_wr_addr] <= req_coef_word;
      coef_q_ff  <= coef_mem[coef_rd_addr];
      coef_qv_ff <= coef_vld_ff[coef_rd_addr];
      coef_q0_ff <= slot_sel == SLOT_B0;
   end

   always_ff @(posedge clock) begin
      if (d1_we) d1_mem[d_addr] <= d1_wdata;
      if (d2_we) d2_mem[d_addr] <= d2_wdata;
      d1_q_ff  <= d1_mem[d_addr];
      d2_q_ff  <= d2_mem[d_addr];
      d1_qv_ff <= d1_vld_ff[d_addr];
      d2_qv_ff <= d2_vld_ff[d_addr];
   end

   always_ff @(posedge clock) begin
      prod_ff <= PW'(mul_a) * PW'(mul_b);
      if (audio_go) begin
         ch_ff <= req_channel;
         x_ff  <= {{4{req_sample_in[23]}}, req_sample_in, 4'b0000};
      end
      case (state_ff)
         ST_B2: y_ff <= 32'(sat(rp27 + PW'(d1_eff), 32));
         ST_B3: acc_ff <= AW'(rp27);
         ST_B4: acc_ff <= AW'(PW'(acc_ff) - rp27 + PW'(d2_eff));
         ST_B5: acc_ff <= AW'(rp27);
         ST_B6: begin
            if (!(is_band && coef_eff != 32'sd0)) x_ff <= y_ff;
         end
         ST_C1: begin
            neg_ff <= u_val < 0;
            mag_ff <= 38'((u_val < 0) ? -u_val : u_val);
         end
         ST_C2: begin
            big_ff  <= mag_ff[37:30] != 8'd0;
            t0_ff   <= TANH_ROM[idx_lo];
            t1_ff   <= TANH_ROM[(TANH_BITS+1)'(idx_lo) + (TANH_BITS+1)'(1)];
            frac_ff <= {mag_ff[29-TANH_BITS:0], {TANH_BITS{1'b0}}};
         end
         ST_C4: t_ff <= t_calc;
         ST_C6: x_ff <= 32'(sat(rp30, 32));
         ST_M1: begin
            if (out_free) begin
               rsp_sample_ff  <= 24'(sat(rnd(prod_ff, 24), 24));
               rsp_channel_ff <= ch_ff;
            end
         end
         default: ;
      endcase
   end

   `BQ_ASSERT(a_audio_starts, clock, reset, audio_go |=> state_ff != ST_IDLE, "audio item not started")
   `BQ_ASSERT(a_rsp_from_gain, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_M1, "result without gain step")
   `BQ_ASSERT(a_stage_range, clock, reset, state_ff != ST_IDLE |-> int'(stage_ff) < STAGES, "stage out of range")
   `BQ_ASSERT_NEVER(a_clip_outside_band, clock, reset, state_ff == ST_C1 && !is_band, "clip on a filter stage")

endmodule

`default_nettype wire

FILE: dv/biquad_eq_chain_soft_clip_core_test.sv
`timescale 1ns / 1ps

module biquad_eq_chain_soft_clip_core_test
   import bqeq_pkg::*;
();

   localparam logic [1:0] MODE_NONE = 2'd3;
   localparam logic [2:0] SLOT_NONE = 3'd7;
   localparam int RUN_LIMIT = 3000000;
   localparam int SETTLE = 200;

   typedef struct {
      logic [1:0]         mode;
      logic               channel;
      logic signed [23:0] sample;
      logic [3:0]         stage;
      logic [2:0]         slot;
      logic signed [31:0] coef;
   } eq_item_type;

   typedef struct {
      logic signed [23:0] sample;
      logic               channel;
   } eq_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_mode = MODE_AUDIO;
   logic req_channel = 1'b0;
   logic signed [23:0] req_sample_in = '0;
   logic [3:0] req_stage_index = '0;
   logic [2:0] req_slot_index = '0;
   logic signed [31:0] req_coef_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [23:0] rsp_sample_out;
   logic rsp_channel_out;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = CSR_GAIN;
   logic [23:0] csr_data = '0;

   biquad_eq_chain_soft_clip_core DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   eq_item_type pending_items[$];
   eq_out_type  expected_samples[$];
   eq_item_type in_flight;
   int       fail_count = 0;
   int       send_idle_pct = 0;
   int       stall_pct = 0;
   logic     pressure_on = 1'b0;
   int       hold_count = 0;
   logic     hold_long;
   int       cycle_count = 0;

   longint   coef_mem[COEF_DEPTH];
   longint   state_one[DELAY_DEPTH];
   longint   state_two[DELAY_DEPTH];
   longint   tanh_table[TANH_POINTS + 1];
   longint   gain_q20 = 1048576;
   bit       hp_on = 1'b0;
   bit       lp_on = 1'b0;

   function automatic longint round_shift(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic longint clamp_bits(longint v, int bits);
      longint hi, lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   function automatic bit [63:0] fixed_mul56(bit [63:0] a, bit [63:0] b);
      bit [63:0] ah, al, bh, bl;
      ah = a >> 32;
      al = a & 64'hFFFF_FFFF;
      bh = b >> 32;
      bl = b & 64'hFFFF_FFFF;
      return ((ah * bh) << 8) + ((ah * bl + al * bh) >> 24) + ((al * bl) >> 56);
   endfunction

   task automatic fill_tanh_table();
      bit [63:0] one, term, ratio, ex, num, den;
      one = 64'd1 << 56;
      term = one;
      ratio = one;
      ex = one;
      for (int n = 1; n < 40; n++) begin
         if (term != 0) begin
            term = term * 64'd16 / (64'(TANH_POINTS) * 64'(n));
            if (n % 2 == 1) ratio = ratio - term;
            else ratio = ratio + term;
         end
      end
      for (int k = 0; k <= TANH_POINTS; k++) begin
         num = (one - ex) >> 26;
         den = (one + ex) >> 26;
         tanh_table[k] = longint'(((num << 30) + den / 2) / den);
         ex = fixed_mul56(ex, ratio);
      end
   endtask

   function automatic longint run_biquad(int stage, int ch, longint x);
      longint y;
      int base, d;
      base = stage * SLOTS;
      d = stage * CHANNELS + ch;
      y = clamp_bits(round_shift(coef_mem[base] * x, 27) + state_one[d], 32);
      state_one[d] = clamp_bits(round_shift(coef_mem[base + 1] * x, 27)
                                - round_shift(coef_mem[base + 3] * y, 27) + state_two[d], 40);
      state_two[d] = clamp_bits(round_shift(coef_mem[base + 2] * x, 27)
                                - round_shift(coef_mem[base + 4] * y, 27), 40);
      return y;
   endfunction

   function automatic longint run_clip(int stage, longint s);
      longint u, t, mag, pos, idx, frac;
      int base;
      base = stage * SLOTS;
      if (coef_mem[base + 5] == 0) return s;
      u = round_shift(s * coef_mem[base + 5], 27);
      mag = u < 0 ? -u : u;
      pos = mag * TANH_POINTS;
      idx = pos >>> 30;
      if (idx >= TANH_POINTS) begin
         t = tanh_table[TANH_POINTS];
      end else begin
         frac = pos & ((longint'(1) <<< 30) - 1);
         t = tanh_table[idx] + round_shift((tanh_table[idx + 1] - tanh_table[idx]) * frac, 30);
      end
      if (u < 0) t = -t;
      return clamp_bits(round_shift(t * coef_mem[base + 6], 30), 32);
   endfunction

   task automatic predict_item(eq_item_type it);
      longint s;
      eq_out_type o;
      case (it.mode)
         MODE_WRITE: begin
            if (it.stage < STAGES && it.slot < SLOTS)
               coef_mem[it.stage * SLOTS + it.slot] = longint'(it.coef);
         end
         MODE_CLEAR: begin
            foreach (state_one[i]) begin
               state_one[i] = 0;
               state_two[i] = 0;
            end
         end
         MODE_AUDIO: begin
            s = longint'(it.sample) * 16;
            if (hp_on) s = run_biquad(0, it.channel, s);
            for (int b = 1; b <= BANDS; b++) begin
               s = run_biquad(b, it.channel, s);
               s = run_clip(b, s);
            end
            if (lp_on) s = run_biquad(STAGES - 1, it.channel, s);
            o.sample = 24'(clamp_bits(round_shift(s * gain_q20, 24), 24));
            o.channel = it.channel;
            expected_samples.push_back(o);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) predict_item(in_flight);
         if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            in_flight = pending_items.pop_front();
            req_mode <= in_flight.mode;
            req_channel <= in_flight.channel;
            req_sample_in <= in_flight.sample;
            req_stage_index <= in_flight.stage;
            req_slot_index <= in_flight.slot;
            req_coef_word <= in_flight.coef;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!pressure_on) hold_count <= 0;
      else if (hold_count < 1000) hold_count <= hold_count + 1;
   end
   assign hold_long = pressure_on && hold_count < 800;

   always @(posedge clock) begin
      eq_out_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            $error("unexpected sample_out %0d channel_out %0d", rsp_sample_out, rsp_channel_out);
            fail_count++;
         end else begin
            e = expected_samples.pop_front();
            if (rsp_sample_out !== e.sample) begin
               $error("sample_out expected %0d actual %0d", e.sample, rsp_sample_out);
               fail_count++;
            end
            if (rsp_channel_out !== e.channel) begin
               $error("channel_out expected %0d actual %0d", e.channel, rsp_channel_out);
               fail_count++;
            end
         end
      end
      rsp_stall <= hold_long || ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [23:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_GAIN: gain_q20 = longint'(value);
         CSR_HP: hp_on = value[0];
         CSR_LP: lp_on = value[0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_items.size() > 0 || req_valid || expected_samples.size() > 0)
         @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic add_item(logic [1:0] mode, logic ch, logic signed [23:0] smp,
                           logic [3:0] stage, logic [2:0] slot, logic signed [31:0] coef);
      eq_item_type it;
      it.mode = mode;
      it.channel = ch;
      it.sample = smp;
      it.stage = stage;
      it.slot = slot;
      it.coef = coef;
      pending_items.push_back(it);
   endtask

   function automatic logic signed [31:0] pick_coef(logic [2:0] slot);
      int d;
      if ($urandom_range(19) == 0) return $urandom;
      case (slot)
         SLOT_B0: return Q27_ONE + $signed($urandom_range(0, 1 << 25)) - (1 << 24);
         SLOT_DRIVE: begin
            if ($urandom_range(2) == 0) return '0;
            return 32'($urandom_range(1, 16)) << 27;
         end
         SLOT_RDRIVE: begin
            d = $urandom_range(1, 16);
            return 32'((1 << 27) / d);
         end
         default: return $signed($urandom_range(0, 1 << 25)) - (1 << 24);
      endcase
   endfunction

   task automatic add_random_item();
      int r;
      logic [3:0] stage;
      logic [2:0] slot;
      logic signed [23:0] smp;
      r = $urandom_range(99);
      if (r < 72) begin
         case ($urandom_range(7))
            0: smp = 24'sh7FFFFF;
            1: smp = -24'sh800000;
            2: smp = 24'($signed($urandom_range(0, 1023)) - 512);
            default: smp = 24'($urandom);
         endcase
         add_item(MODE_AUDIO, 1'($urandom_range(1)), smp, '0, '0, '0);
      end else if (r < 94) begin
         stage = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(STAGES - 1));
         slot = ($urandom_range(14) == 0) ? SLOT_NONE : 3'($urandom_range(SLOTS - 1));
         add_item(MODE_WRITE, 1'($urandom_range(1)), 24'($urandom), stage, slot,
                  pick_coef(slot));
      end else if (r < 97) begin
         add_item(MODE_CLEAR, 1'($urandom_range(1)), 24'($urandom), 4'($urandom),
                  3'($urandom), $urandom);
      end else begin
         add_item(MODE_NONE, 1'($urandom_range(1)), 24'($urandom), 4'($urandom),
                  3'($urandom), $urandom);
      end
   endtask

   initial begin
      logic [23:0] gain_pick;
      foreach (coef_mem[i]) coef_mem[i] = (i % SLOTS == 0) ? longint'(Q27_ONE) : 0;
      foreach (state_one[i]) begin
         state_one[i] = 0;
         state_two[i] = 0;
      end
      fill_tanh_table();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      add_item(MODE_AUDIO, 1'b0, 24'sh7FFFFF, '0, '0, '0);
      add_item(MODE_AUDIO, 1'b1, -24'sh800000, '0, '0, '0);
      add_item(MODE_AUDIO, 1'b0, '0, '0, '0, '0);
      add_item(MODE_WRITE, 1'b0, '0, 4'd3, SLOT_B0, 32'sh0C00_0000);
      add_item(MODE_WRITE, 1'b0, '0, 4'd3, SLOT_B1, -32'sh0100_0000);
      add_item(MODE_WRITE, 1'b0, '0, 4'd3, SLOT_B2, 32'sh0080_0000);
      add_item(MODE_WRITE, 1'b0, '0, 4'd3, SLOT_A1, -32'sh0200_0000);
      add_item(MODE_WRITE, 1'b0, '0, 4'd3, SLOT_A2, 32'sh0100_0000);
      add_item(MODE_WRITE, 1'b0, '0, 4'd3, SLOT_DRIVE, 32'sh2000_0000);
      add_item(MODE_WRITE, 1'b0, '0, 4'd3, SLOT_RDRIVE, 32'sh0200_0000);
      add_item(MODE_WRITE, 1'b0, '0, 4'd0, SLOT_DRIVE, 32'sh7FFF_FFFF);
      add_item(MODE_WRITE, 1'b0, '0, 4'd10, SLOT_B0, -32'sh8000_0000);
      add_item(MODE_WRITE, 1'b0, '0, 4'd15, SLOT_B0, 32'sh0000_0000);
      add_item(MODE_WRITE, 1'b0, '0, 4'd2, SLOT_NONE, 32'sh7FFF_FFFF);
      add_item(MODE_AUDIO, 1'b0, 24'sh7FFFFF, '0, '0, '0);
      add_item(MODE_AUDIO, 1'b1, -24'sh800000, '0, '0, '0);
      add_item(MODE_AUDIO, 1'b0, 24'sh001000, '0, '0, '0);
      add_item(MODE_NONE, 1'b1, 24'sh123456, 4'd1, SLOT_B1, 32'sh0000_1000);
      add_item(MODE_CLEAR, 1'b0, '0, '0, '0, '0);
      add_item(MODE_AUDIO, 1'b1, 24'sh400000, '0, '0, '0);
      add_item(MODE_WRITE, 1'b0, '0, 4'd3, SLOT_DRIVE, '0);
      add_item(MODE_AUDIO, 1'b0, -24'sh400000, '0, '0, '0);
      drain();

      for (int p = 0; p < 16; p++) begin
         case (p % 4)
            0: gain_pick = 24'hFFFFFF;
            1: gain_pick = '0;
            2: gain_pick = GAIN_RESET;
            default: gain_pick = 24'($urandom);
         endcase
         write_csr(CSR_GAIN, gain_pick);
         write_csr(CSR_HP, 24'((p >> 1) & 1));
         write_csr(CSR_LP, 24'(((p >> 1) ^ p) & 1));
         case (p / 4)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 80; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 80; end
            default: begin send_idle_pct = 32; stall_pct = 32; end
         endcase
         pressure_on = (p == 8);
         repeat (108) add_random_item();
         drain();
         pressure_on = 1'b0;
         send_idle_pct = 0;
         stall_pct = 0;
      end

      if (fail_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
